FILE: rtl/mmd_pkg.sv
// ============================================================================
// mmd_pkg: shared types, constants and pattern helpers for the deframer
// Holds the result beat layout, result and error codes, the fixed header
// patterns and the per-byte step functions of the two substring searches.
// ============================================================================
`default_nettype none

package mmd_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int COUNT_BITS  = 16;

    localparam int BND_LEN  = 10;
    localparam int TYPE_LEN = 24;
    localparam int PFX_LEN  = 16;

    localparam logic [8*BND_LEN-1:0]  BND_PAT  = "--boundary";
    localparam logic [8*TYPE_LEN-1:0] TYPE_PAT = "Content-Type: image/jpeg";
    localparam logic [8*PFX_LEN-1:0]  PFX_PAT  = "Content-Length: ";

    // Match positions used by the length line: prefix done, and value over limit.
    localparam logic [4:0] LEN_PREFIX = 5'd16;
    localparam logic [4:0] LEN_OVER   = 5'd17;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BOUNDARY  = 3'd1,
        ERR_TYPE      = 3'd2,
        ERR_SYNTAX    = 3'd3,
        ERR_OVER      = 3'd4,
        ERR_SEPARATOR = 3'd5
    } err_t;

    typedef struct packed {
        kind_t                 kind;
        err_t                  code;
        logic [7:0]            data;
        logic                  last;
        logic [COUNT_BITS-1:0] index;
    } res_t;

    function automatic logic [7:0] bnd_char(logic [4:0] pos);
        int idx;
        idx = BND_LEN - 1 - int'(pos);
        return BND_PAT[8*idx +: 8];
    endfunction

    function automatic logic [7:0] type_char(logic [4:0] pos);
        int idx;
        idx = TYPE_LEN - 1 - int'(pos);
        return TYPE_PAT[8*idx +: 8];
    endfunction

    function automatic logic [7:0] pfx_char(logic [4:0] pos);
        int idx;
        idx = PFX_LEN - 1 - int'(pos);
        return PFX_PAT[8*idx +: 8];
    endfunction

    // Search step for "--boundary". The only self-overlap is the leading
    // dash pair, so a mismatch falls back to one or two dashes or to zero.
    function automatic logic [4:0] bnd_step(logic [4:0] pos, logic [7:0] c);
        logic [4:0] r;
        if (pos < 5'(BND_LEN) && c == bnd_char(pos))
        begin
            r = pos + 5'd1;
        end
        else if (c == "-")
        begin
            r = (pos == 5'd2) ? 5'd2 : 5'd1;
        end
        else
        begin
            r = 5'd0;
        end
        return r;
    endfunction

    // Search step for the type line. The capital C appears only at the start.
    function automatic logic [4:0] type_step(logic [4:0] pos, logic [7:0] c);
        logic [4:0] r;
        if (pos < 5'(TYPE_LEN) && c == type_char(pos))
        begin
            r = pos + 5'd1;
        end
        else if (c == "C")
        begin
            r = 5'd1;
        end
        else
        begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mmd_out_buffer.sv
// ============================================================================
// mmd_out_buffer: two-entry result buffer
// An output register backed by a skid register, so the parser keeps taking
// bytes for one more beat while the downstream side stalls.
// ============================================================================
`default_nettype none

module mmd_out_buffer
    import mmd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_res,
    output logic      space,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            // The output slot frees up: the oldest held beat moves forward.
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                out_res_reg    <= skid_res_reg;
                skid_valid_reg <= push;
                skid_res_reg   <= push_res;
            end
            else
            begin
                out_valid_reg <= push;
                out_res_reg   <= push_res;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
            skid_res_reg   <= push_res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mjpeg_multipart_deframer.sv
// ============================================================================
// mjpeg_multipart_deframer: multipart MJPEG stream deframer
// Parses boundary, content type, content length and separator lines of a
// multipart camera stream and passes the image payload through byte by byte.
// ============================================================================
// A result beat is registered in the output buffer before it reaches the
// master side. Throughput: one byte per cycle while the buffer has space; a
// two-entry output buffer lets one more byte in while the master side stalls.
// Reset (rst_n low, asynchronous) returns the parser to waiting for a boundary
// line, clears the image count and loads a content length limit of 1048576
// bytes.
`default_nettype none

module mjpeg_multipart_deframer
    import mmd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration: largest accepted content length.
    input  wire logic                   cfg_we,
    input  wire logic [LENGTH_BITS-1:0] cfg_wdata,
    // Slave side. tdata: in_byte[7:0].
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,
    // Master side. tdata: error_code[2:0], image_byte[10:3], image_index[26:11],
    // zero fill [31:27]. tuser: result_kind[1:0]. tlast: last_of_image.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [31:0]                 m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam logic [LENGTH_BITS-1:0] MAX_RESET = LENGTH_BITS'(1048576);

    typedef enum logic [2:0] {
        PH_BOUNDARY = 3'd0,
        PH_TYPE     = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_SEP      = 3'd3,
        PH_IMAGE    = 3'd4,
        PH_RESYNC   = 3'd5
    } phase_t;

    // Per-line parse state. In the length line, pos walks the prefix and then
    // marks whether the value went over the limit; matched flags a syntax
    // fault there and a found pattern in the other lines.
    typedef struct packed {
        logic [4:0]             pos;
        logic                   matched;
        logic                   has_bytes;
        logic [LENGTH_BITS-1:0] value;
    } line_t;

    logic [LENGTH_BITS-1:0] max_bytes_reg;
    phase_t                 phase_reg, phase_next;
    line_t                  line_reg, line_next;
    logic                   cr_seen_reg, cr_seen_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [COUNT_BITS-1:0]  done_reg, done_next;

    logic accept;
    logic push;
    res_t push_res;
    res_t out_res;
    line_t fed_cr;
    line_t fed_byte;

    // One byte of line content through the parser of the current line.
    function automatic line_t feed(phase_t ph, line_t s, logic [7:0] c,
                                   logic [LENGTH_BITS-1:0] limit);
        line_t r;
        logic [4:0] p;
        logic [LENGTH_BITS+3:0] v;
        r = s;
        v = ({4'd0, s.value} << 3) + ({4'd0, s.value} << 1)
            + (LENGTH_BITS+4)'(c[3:0]);
        unique case (ph)
            PH_TYPE:
            begin
                if (!s.matched)
                begin
                    p = (s.pos >= 5'(TYPE_LEN)) ? 5'd0 : s.pos;
                    r.pos = type_step(p, c);
                    if (r.pos >= 5'(TYPE_LEN))
                    begin
                        r.matched = 1'b1;
                    end
                end
            end
            PH_LENGTH:
            begin
                if (!s.matched)
                begin
                    if (s.pos < LEN_PREFIX)
                    begin
                        if (pfx_char(s.pos) == c)
                        begin
                            r.pos = s.pos + 5'd1;
                        end
                        else
                        begin
                            r.matched = 1'b1;
                        end
                    end
                    else if (c < "0" || c > "9")
                    begin
                        r.matched = 1'b1;
                    end
                    else
                    begin
                        r.has_bytes = 1'b1;
                        // Accumulation stops at the first digit over the limit.
                        if (s.pos == LEN_PREFIX)
                        begin
                            if (v > {4'd0, limit})
                            begin
                                r.pos = LEN_OVER;
                            end
                            else
                            begin
                                r.value = v[LENGTH_BITS-1:0];
                            end
                        end
                    end
                end
            end
            PH_SEP:
            begin
                r.has_bytes = 1'b1;
            end
            default:
            begin
                // Boundary and resync lines both search for the boundary marker.
                if (!s.matched)
                begin
                    p = (s.pos >= 5'(BND_LEN)) ? 5'd0 : s.pos;
                    r.pos = bnd_step(p, c);
                    if (r.pos >= 5'(BND_LEN))
                    begin
                        r.matched = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    assign accept = s_tvalid && s_tready;

    // A held CR that is not followed by LF is line content, and so may be the
    // byte after it: both go through the parser in the same cycle.
    assign fed_cr   = feed(phase_reg, line_reg, CHAR_CR, max_bytes_reg);
    assign fed_byte = feed(phase_reg, cr_seen_reg ? fed_cr : line_reg, s_tdata,
                           max_bytes_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        line_next    = line_reg;
        cr_seen_next = cr_seen_reg;
        left_next    = left_reg;
        done_next    = done_reg;
        push         = 1'b0;
        push_res     = '{kind: KIND_ERROR, code: ERR_NONE, data: 8'd0, last: 1'b0,
                         index: done_reg};

        if (accept)
        begin
            if (phase_reg == PH_IMAGE)
            begin
                // Payload bytes pass through untouched, CR and LF included.
                push          = 1'b1;
                push_res.kind = KIND_BYTE;
                push_res.data = s_tdata;
                push_res.last = (left_reg <= LENGTH_BITS'(1));
                if (left_reg <= LENGTH_BITS'(1))
                begin
                    left_next         = '0;
                    done_next         = done_reg + COUNT_BITS'(1);
                    phase_next        = PH_BOUNDARY;
                    line_next.pos       = 5'd0;
                    line_next.matched   = 1'b0;
                    line_next.has_bytes = 1'b0;
                    cr_seen_next      = 1'b0;
                end
                else
                begin
                    left_next = left_reg - LENGTH_BITS'(1);
                end
            end
            else if (cr_seen_reg && s_tdata == CHAR_LF)
            begin
                // End of line: judge the line just parsed.
                cr_seen_next        = 1'b0;
                line_next.pos       = 5'd0;
                line_next.matched   = 1'b0;
                line_next.has_bytes = 1'b0;
                unique case (phase_reg)
                    PH_BOUNDARY:
                    begin
                        if (line_reg.matched)
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            push          = 1'b1;
                            push_res.code = ERR_BOUNDARY;
                            phase_next    = PH_RESYNC;
                        end
                    end
                    PH_TYPE:
                    begin
                        if (line_reg.matched)
                        begin
                            phase_next = PH_LENGTH;
                        end
                        else
                        begin
                            push          = 1'b1;
                            push_res.code = ERR_TYPE;
                            phase_next    = PH_RESYNC;
                        end
                    end
                    PH_LENGTH:
                    begin
                        // Syntax faults win over the limit check.
                        if (line_reg.matched || !line_reg.has_bytes)
                        begin
                            push          = 1'b1;
                            push_res.code = ERR_SYNTAX;
                            phase_next    = PH_RESYNC;
                        end
                        else if (line_reg.pos == LEN_OVER)
                        begin
                            push          = 1'b1;
                            push_res.code = ERR_OVER;
                            phase_next    = PH_RESYNC;
                        end
                        else
                        begin
                            left_next  = line_reg.value;
                            phase_next = PH_SEP;
                        end
                        line_next.value = '0;
                    end
                    PH_SEP:
                    begin
                        if (line_reg.has_bytes)
                        begin
                            push          = 1'b1;
                            push_res.code = ERR_SEPARATOR;
                            phase_next    = PH_RESYNC;
                        end
                        else if (left_reg == '0)
                        begin
                            // A zero length closes an empty image right here.
                            push          = 1'b1;
                            push_res.kind = KIND_EMPTY;
                            done_next     = done_reg + COUNT_BITS'(1);
                            phase_next    = PH_BOUNDARY;
                        end
                        else
                        begin
                            phase_next = PH_IMAGE;
                        end
                    end
                    default:
                    begin
                        phase_next = line_reg.matched ? PH_TYPE : PH_RESYNC;
                    end
                endcase
            end
            else if (cr_seen_reg)
            begin
                // A second CR stays held as a possible line end.
                if (s_tdata == CHAR_CR)
                begin
                    line_next = fed_cr;
                end
                else
                begin
                    line_next    = fed_byte;
                    cr_seen_next = 1'b0;
                end
            end
            else if (s_tdata == CHAR_CR)
            begin
                cr_seen_next = 1'b1;
            end
            else
            begin
                line_next = fed_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_RESET;
            phase_reg     <= PH_BOUNDARY;
            line_reg      <= '0;
            cr_seen_reg   <= 1'b0;
            left_reg      <= '0;
            done_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_bytes_reg <= cfg_wdata;
            end
            phase_reg   <= phase_next;
            line_reg    <= line_next;
            cr_seen_reg <= cr_seen_next;
            left_reg    <= left_next;
            done_reg    <= done_next;
        end
    end

    mmd_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.index, out_res.data, out_res.code};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire
